@@ rtl/core/pwc_pkg.sv @@
// Package for the pointwise convolution engine: sizes, opcodes, fixed-point constants
// and the control word that the sequencer passes to the shared MAC unit.
// No dependencies.
package pwc_pkg;

    localparam int MAX_IN       = 64;
    localparam int MAX_OUT      = 64;
    localparam int IN_W         = $clog2(MAX_IN);
    localparam int OUT_W        = $clog2(MAX_OUT);
    localparam int WADDR_W      = IN_W + OUT_W;
    localparam int CNT_W        = 7;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int FRAC_SHIFT   = 14;
    localparam int ACC_W        = PROD_W + $clog2(MAX_IN) + 1;
    localparam int ACT_W        = 15;
    localparam int RELU6_TOP    = 24576;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_PIXEL  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_CHANNELS  = 2'd0,
        REG_OUT_CHANNELS = 2'd1
    } cfg_reg_t;

    // one MAC step: valid, start of a new dot product, end of it
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_op_t;

endpackage

@@ rtl/core/pwc_mac.sv @@
// Shared multiply-accumulate unit with bias preload and ReLU6 clamp.
// Depends on pwc_pkg.
module pwc_mac
    import pwc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_op_t                  op_i,
    input  logic signed [VAL_W-1:0]  pixel_i,
    input  logic signed [VAL_W-1:0]  weight_i,
    input  logic signed [VAL_W-1:0]  bias_i,
    output logic                     done_o,
    output logic [ACT_W-1:0]         result_o
);

    mac_op_t                   op1_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VAL_W-1:0]   bias1_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_base;
    logic                      done_reg;
    logic [ACC_W-FRAC_SHIFT-1:0] acc_q412;

    // stage 1: product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_reg <= '0;
        end else begin
            op1_reg <= op_i;
        end
        prod_reg  <= pixel_i * weight_i;
        bias1_reg <= bias_i;
    end

    // stage 2: accumulate; start from bias in Q.26 on the first product
    always_comb begin
        if (op1_reg.first) begin
            acc_base = {{(ACC_W-VAL_W-FRAC_SHIFT){bias1_reg[VAL_W-1]}}, bias1_reg,
                        {FRAC_SHIFT{1'b0}}};
        end else begin
            acc_base = acc_reg;
        end
        acc_next = acc_base + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= op1_reg.valid & op1_reg.last;
        end
        if (op1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // truncate toward minus infinity, then clamp to [0, 6.0]
    assign acc_q412 = acc_reg[ACC_W-1:FRAC_SHIFT];

    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            result_o = '0;
        end else if (acc_q412 > (ACC_W-FRAC_SHIFT)'(RELU6_TOP)) begin
            result_o = ACT_W'(RELU6_TOP);
        end else begin
            result_o = acc_q412[ACT_W-1:0];
        end
    end

    assign done_o = done_reg;

endmodule

@@ rtl/core/pointwise_conv_relu6.sv @@
// Top level of the pointwise (1x1) convolution engine with bias and ReLU6.
// Holds the weight, bias and pixel memories and the sequencer; uses pwc_pkg and pwc_mac.
//
// Usage: the s_ channel carries one word per item: a weight load, a bias load or one
// input-channel value of a pixel. Loads and non-final pixel values are taken while
// idle. The pixel value for input channel in_channels-1 starts a computation:
// for each output channel the shared MAC runs through in_channels products, one per
// cycle, then the clamped result is handed to the m_ channel, with m_last on the final
// output channel. s_ready stays low until the last result sits in the output register.
// Each output channel issues its products, then runs through the registered memory
// reads, the product register, the accumulator with its done flag and the emit step
// that loads the output register; the output channels of a pixel follow one another,
// all on one 16x16 multiplier.
// The output register parts the two sides: while a result waits on m_ready, the
// sequencer holds in its emit step and the MAC sits still; no result is lost.
// The cfg_ channel writes in_channels (index 0) or out_channels (index 1) and is
// always ready; write only while idle. Reset clears the sequencer, the output valid
// and sets both counts to 64; the memories hold garbage until loaded.
module pointwise_conv_relu6
    import pwc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CNT_W-1:0]         cfg_data,
    // input words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [OUT_W-1:0]         s_out_index,
    input  logic [IN_W-1:0]          s_in_index,
    input  logic signed [VAL_W-1:0]  s_value,
    // result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OUT_W-1:0]         m_out_channel,
    output logic [ACT_W-1:0]         m_activation,
    output logic                     m_last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          in_ch_reg, out_ch_reg;
    logic [IN_W-1:0]           in_last;
    logic [OUT_W-1:0]          out_last;
    logic [IN_W-1:0]           ic_reg, ic_next;
    logic [OUT_W-1:0]          oc_reg, oc_next;

    logic                      s_take;
    logic                      wr_weight, wr_bias, wr_pixel, start;

    logic signed [VAL_W-1:0]   weight_mem [MAX_OUT*MAX_IN];
    logic signed [VAL_W-1:0]   bias_mem   [MAX_OUT];
    logic signed [VAL_W-1:0]   pixel_mem  [MAX_IN];
    logic signed [VAL_W-1:0]   weight_q, bias_q, pixel_q;
    logic [WADDR_W-1:0]        weight_waddr, weight_raddr;

    mac_op_t                   issue_op, op_q_reg;
    logic                      mac_done;
    logic [ACT_W-1:0]          mac_result;

    logic                      out_free;
    logic                      m_valid_reg;
    logic [OUT_W-1:0]          m_out_channel_reg;
    logic [ACT_W-1:0]          m_activation_reg;
    logic                      m_last_reg;

    // ---------------------------------------------------------------
    // Configuration: always ready; counts saturate to [1, MAX] in use
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= CNT_W'(MAX_IN);
            out_ch_reg <= CNT_W'(MAX_OUT);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IN_CHANNELS:  in_ch_reg  <= cfg_data;
                REG_OUT_CHANNELS: out_ch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (in_ch_reg == '0) begin
            in_last = '0;
        end else if (int'(in_ch_reg) > MAX_IN) begin
            in_last = IN_W'(MAX_IN - 1);
        end else begin
            in_last = IN_W'(in_ch_reg - CNT_W'(1));
        end
        if (out_ch_reg == '0) begin
            out_last = '0;
        end else if (int'(out_ch_reg) > MAX_OUT) begin
            out_last = OUT_W'(MAX_OUT - 1);
        end else begin
            out_last = OUT_W'(out_ch_reg - CNT_W'(1));
        end
    end

    // ---------------------------------------------------------------
    // Input decode: loads land in the memories in the accept cycle
    // ---------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;

    always_comb begin
        wr_weight = 1'b0;
        wr_bias   = 1'b0;
        wr_pixel  = 1'b0;
        case (s_opcode)
            OP_WEIGHT: wr_weight = s_take && (int'(s_out_index) < MAX_OUT)
                                          && (int'(s_in_index) < MAX_IN);
            OP_BIAS:   wr_bias   = s_take && (int'(s_out_index) < MAX_OUT);
            OP_PIXEL:  wr_pixel  = s_take && (int'(s_in_index) < MAX_IN);
            default: ;
        endcase
    end

    // the final channel of a pixel kicks off the dot products
    assign start = wr_pixel && (s_in_index == in_last);

    // weight entry is out*MAX_IN + in; MAX_IN is a power of two
    assign weight_waddr = {s_out_index, s_in_index};
    assign weight_raddr = {oc_reg, ic_reg};

    // ---------------------------------------------------------------
    // Memories: one write port, one registered read port each
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_weight) begin
            weight_mem[weight_waddr] <= s_value;
        end
        weight_q <= weight_mem[weight_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr_bias) begin
            bias_mem[s_out_index] <= s_value;
        end
        bias_q <= bias_mem[oc_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_pixel) begin
            pixel_mem[s_in_index] <= s_value;
        end
        pixel_q <= pixel_mem[ic_reg];
    end

    // ---------------------------------------------------------------
    // Sequencer: issue one product per cycle, wait for the sum, emit
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        ic_next    = ic_reg;
        oc_next    = oc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_MAC;
                    ic_next    = '0;
                    oc_next    = '0;
                end
            end
            ST_MAC: begin
                if (ic_reg == in_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    ic_next = ic_reg + IN_W'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    if (oc_reg == out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_MAC;
                        oc_next    = oc_reg + OUT_W'(1);
                        ic_next    = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ic_reg    <= '0;
            oc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ic_reg    <= ic_next;
            oc_reg    <= oc_next;
        end
    end

    // align the step flags with the registered memory data
    assign issue_op.valid = (state_reg == ST_MAC);
    assign issue_op.first = (ic_reg == '0);
    assign issue_op.last  = (ic_reg == in_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_q_reg <= '0;
        end else begin
            op_q_reg <= issue_op;
        end
    end

    pwc_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_i     (op_q_reg),
        .pixel_i  (pixel_q),
        .weight_i (weight_q),
        .bias_i   (bias_q),
        .done_o   (mac_done),
        .result_o (mac_result)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_out_channel_reg <= oc_reg;
            m_activation_reg  <= mac_result;
            m_last_reg        <= (oc_reg == out_last);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_activation  = m_activation_reg;
    assign m_last        = m_last_reg;

endmodule

@@ dv/tb_pointwise_conv_relu6.sv @@
// Self-checking testbench for pointwise_conv_relu6: weight, bias and pixel words go in on
// the s_ channel, and each result word on the m_ channel is checked against a bit-exact
// fixed-point predictor of the 1x1 convolution with ReLU6. Depends on pwc_pkg and the RTL.
module tb_pointwise_conv_relu6;
    import pwc_pkg::*;

    // opcode 3 has no meaning; the block must swallow it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 120;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        logic [OUT_W-1:0] channel;
        logic [ACT_W-1:0] act;
        logic             last;
    } pixel_result_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    // one row of the directed table: a register write or one input word, with the
    // activation typed in where it is obvious (single output channel, extremes)
    typedef struct {
        row_kind_t        kind;
        cfg_reg_t         reg_idx;
        logic [CNT_W-1:0] reg_data;
        logic [1:0]       op;
        logic [OUT_W-1:0] oi;
        logic [IN_W-1:0]  ii;
        logic [VAL_W-1:0] val;
        bit               typed;
        logic [ACT_W-1:0] act;
    } stim_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CNT_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_opcode;
    logic [OUT_W-1:0]        s_out_index;
    logic [IN_W-1:0]         s_in_index;
    logic signed [VAL_W-1:0] s_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [OUT_W-1:0]        m_out_channel;
    logic [ACT_W-1:0]        m_activation;
    logic                    m_last;

    // predictor copy of the block's tables and registers; the *_set flags track which
    // entries were loaded, so a final pixel word never reads an unloaded entry
    logic signed [VAL_W-1:0] wt_mem   [MAX_OUT*MAX_IN];
    logic signed [VAL_W-1:0] bias_mem [MAX_OUT];
    logic signed [VAL_W-1:0] pix_mem  [MAX_IN];
    bit                      wt_set   [MAX_OUT*MAX_IN];
    bit                      bias_set [MAX_OUT];
    bit                      pix_set  [MAX_IN];
    logic [CNT_W-1:0]        in_ch_reg;
    logic [CNT_W-1:0]        out_ch_reg;

    pixel_result_t pixel_results_due[$];
    pixel_result_t head_due;
    stim_row_t     directed_rows[$];

    int  err_count;
    int  words_sent;
    int  random_words;
    int  results_checked;
    int  reg_writes;
    int  cycles;
    bit  s_burst;
    bit  m_burst;

    pointwise_conv_relu6 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_out_index   (s_out_index),
        .s_in_index    (s_in_index),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_activation  (m_activation),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run; the limit sits far above the slowest legal run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s got %0d, want %0d", $time, what, got, want);
    endtask

    // Count as the block uses it: zero acts as one, anything above the table size saturates.
    function automatic int used_count(input logic [CNT_W-1:0] raw, input int top);
        if (raw == 0) return 1;
        if (int'(raw) > top) return top;
        return int'(raw);
    endfunction

    // Mix of full-range, mid-range and extreme 16-bit values.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return VAL_W'($urandom_range(0, 4096));
            1: return VAL_W'($urandom_range(0, 4096) - 2048);
            2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Sender gap: mostly none or short, a few long, with no-gap stretches in between.
    function automatic int sender_gap();
        if ($urandom_range(0, 24) == 0) s_burst = !s_burst;
        if (s_burst) return 0;
        case ($urandom_range(0, 19))
            0, 1:          return $urandom_range(10, 40);
            2, 3, 4, 5, 6: return $urandom_range(1, 3);
            default:       return 0;
        endcase
    endfunction

    // Apply one accepted word to the predictor state. A pixel word for the last used
    // input channel queues one result per used output channel.
    task automatic absorb_word(input logic [1:0] op, input logic [OUT_W-1:0] oi,
                               input logic [IN_W-1:0] ii, input logic [VAL_W-1:0] val,
                               output int made);
        int            n_in;
        int            n_out;
        longint        acc;
        longint        res;
        pixel_result_t r;
        made  = 0;
        n_in  = used_count(in_ch_reg, MAX_IN);
        n_out = used_count(out_ch_reg, MAX_OUT);
        case (op)
            OP_WEIGHT: begin
                wt_mem[int'(oi)*MAX_IN + int'(ii)] = val;
                wt_set[int'(oi)*MAX_IN + int'(ii)] = 1'b1;
            end
            OP_BIAS: begin
                bias_mem[oi] = val;
                bias_set[oi] = 1'b1;
            end
            OP_PIXEL: begin
                pix_mem[ii] = val;
                pix_set[ii] = 1'b1;
                if (int'(ii) == n_in - 1) begin
                    for (int oc = 0; oc < n_out; oc++) begin
                        // bias in Q4.12 lines up with Q6.26 products after 14 bits of shift
                        acc = longint'(bias_mem[oc]) <<< FRAC_SHIFT;
                        for (int ic = 0; ic < n_in; ic++)
                            acc += longint'(pix_mem[ic]) * longint'(wt_mem[oc*MAX_IN + ic]);
                        res = (acc < 0) ? 64'sd0 : (acc >>> FRAC_SHIFT);
                        if (res > RELU6_TOP) res = RELU6_TOP;
                        r.channel = OUT_W'(oc);
                        r.act     = ACT_W'(res);
                        r.last    = (oc == n_out - 1);
                        pixel_results_due.push_back(r);
                        made++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Present one word and hold it until accepted. Enter and leave at a falling edge;
    // valid stays high on exit so back-to-back words follow without a gap.
    task automatic drive_word(input logic [1:0] op, input logic [OUT_W-1:0] oi,
                              input logic [IN_W-1:0] ii, input logic [VAL_W-1:0] val,
                              input bit typed = 1'b0, input logic [ACT_W-1:0] act = '0);
        int gap;
        int made;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_out_index <= oi;
        s_in_index  <= ii;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        absorb_word(op, oi, ii, val, made);
        // a typed row overrides the prediction with the value read off by hand
        if (typed && made > 0)
            pixel_results_due[pixel_results_due.size()-1].act = act;
        words_sent++;
        @(negedge aclk);
    endtask

    // Send a word; ahead of a final pixel word, load every table entry it will read
    // that has not been loaded since reset.
    task automatic send_item(input logic [1:0] op, input logic [OUT_W-1:0] oi,
                             input logic [IN_W-1:0] ii, input logic [VAL_W-1:0] val,
                             input bit typed = 1'b0, input logic [ACT_W-1:0] act = '0);
        int n_in;
        int n_out;
        n_in  = used_count(in_ch_reg, MAX_IN);
        n_out = used_count(out_ch_reg, MAX_OUT);
        if (op == OP_PIXEL && int'(ii) == n_in - 1) begin
            for (int oc = 0; oc < n_out; oc++) begin
                if (!bias_set[oc])
                    drive_word(OP_BIAS, OUT_W'(oc), IN_W'($urandom), pick_value());
                for (int ic = 0; ic < n_in; ic++)
                    if (!wt_set[oc*MAX_IN + ic])
                        drive_word(OP_WEIGHT, OUT_W'(oc), IN_W'(ic), pick_value());
            end
            for (int ic = 0; ic < n_in - 1; ic++)
                if (!pix_set[ic])
                    drive_word(OP_PIXEL, OUT_W'($urandom), IN_W'(ic), pick_value());
        end
        drive_word(op, oi, ii, val, typed, act);
    endtask

    // Drop valid and hold until every queued result has come out.
    task automatic drain_pause();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pixel_results_due.size() != 0) @(negedge aclk);
    endtask

    // Drain, then give the block time to retire any load still in flight.
    task automatic settle_idle();
        drain_pause();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write; enter at a falling edge and leave at a falling edge with valid low.
    task automatic write_reg(input cfg_reg_t idx, input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_IN_CHANNELS) in_ch_reg = data;
        else                        out_ch_reg = data;
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic void add_reg(input cfg_reg_t idx, input int data);
        stim_row_t row;
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = CNT_W'(data);
        row.op       = '0;
        row.oi       = '0;
        row.ii       = '0;
        row.val      = '0;
        row.typed    = 1'b0;
        row.act      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_word(input logic [1:0] op, input int oi, input int ii,
                                     input logic [VAL_W-1:0] val, input bit typed,
                                     input int act);
        stim_row_t row;
        row.kind     = ROW_WORD;
        row.reg_idx  = REG_IN_CHANNELS;
        row.reg_data = '0;
        row.op       = op;
        row.oi       = OUT_W'(oi);
        row.ii       = IN_W'(ii);
        row.val      = val;
        row.typed    = typed;
        row.act      = ACT_W'(act);
        directed_rows.push_back(row);
    endfunction

    // Random stalls on the result side: mostly short, a few long, with stall-free stretches.
    initial begin
        int stall;
        stall   = 0;
        m_burst = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall == 0 && $urandom_range(0, 63) == 0) m_burst = !m_burst;
            if (stall > 0) begin
                stall--;
            end else if (!m_burst) begin
                case ($urandom_range(0, 19))
                    0:          stall = $urandom_range(10, 40);
                    1, 2, 3, 4: stall = $urandom_range(1, 3);
                    default:    stall = 0;
                endcase
            end
            m_ready <= (stall == 0);
        end
    end

    // Check each accepted result word against the oldest pending prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pixel_results_due.size() == 0) begin
                note_mismatch("result word with nothing pending, out_channel",
                              int'(m_out_channel), -1);
            end else begin
                head_due = pixel_results_due.pop_front();
                if (m_out_channel !== head_due.channel)
                    note_mismatch("out_channel", int'(m_out_channel), int'(head_due.channel));
                if (m_activation !== head_due.act)
                    note_mismatch("activation", int'(m_activation), int'(head_due.act));
                if (m_last !== head_due.last)
                    note_mismatch("last", int'(m_last), int'(head_due.last));
            end
        end
    end

    initial begin
        int               n_in;
        int               n_out;
        int               phase_end;
        int               start;
        bit               paused_once;
        logic [CNT_W-1:0] in_raw;
        logic [CNT_W-1:0] out_raw;
        logic [OUT_W-1:0] oi;
        logic [IN_W-1:0]  ii;

        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_IN_CHANNELS;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_opcode    = OP_WEIGHT;
        s_out_index = '0;
        s_in_index  = '0;
        s_value     = '0;
        in_ch_reg   = CNT_W'(MAX_IN);
        out_ch_reg  = CNT_W'(MAX_OUT);
        paused_once = 1'b0;

        // Directed table. One output channel first, so the extremes can be typed in:
        // weight 1.0 passes the pixel through, weight -2.0 with full bias saturates both ways.
        add_reg (REG_IN_CHANNELS, 0);                       // zero acts as one channel
        add_reg (REG_OUT_CHANNELS, 1);
        add_word(OP_WEIGHT, 0, 0, 16'h4000, 0, 0);
        add_word(OP_BIAS,   0, 0, 16'h0000, 0, 0);
        add_word(OP_PIXEL,  0, 0, 16'h7FFF, 1, RELU6_TOP);  // above 6.0: clamp
        add_word(OP_PIXEL,  0, 0, 16'h8000, 1, 0);          // negative: clamp to zero
        add_word(OP_PIXEL,  0, 0, 16'h0000, 1, 0);
        add_word(OP_PIXEL, 63, 0, 16'h1000, 1, 4096);       // out_index means nothing here
        add_word(OP_BIAS,   0, 63, 16'h7FFF, 0, 0);         // in_index means nothing here
        add_word(OP_WEIGHT, 0, 0, 16'h8000, 0, 0);
        add_word(OP_PIXEL,  0, 0, 16'h7FFF, 1, 0);
        add_word(OP_PIXEL,  0, 0, 16'h8000, 1, RELU6_TOP);
        add_word(OP_UNUSED, 63, 63, 16'hFFFF, 0, 0);        // unused opcode: no result
        add_word(OP_PIXEL,  0, 63, 16'h5555, 0, 0);         // not the final channel: store only
        add_word(OP_WEIGHT, 63, 63, 16'hAAAA, 0, 0);
        add_word(OP_BIAS,   63, 0, 16'h8001, 0, 0);
        // oversized counts saturate at the table size
        add_reg (REG_IN_CHANNELS, 127);
        add_reg (REG_OUT_CHANNELS, 0);
        add_word(OP_PIXEL,  0, 10, 16'h0800, 0, 0);
        add_word(OP_PIXEL,  0, 63, 16'h4000, 0, 0);
        add_reg (REG_IN_CHANNELS, 1);
        add_reg (REG_OUT_CHANNELS, 127);
        add_word(OP_PIXEL, 21, 0, 16'h2000, 0, 0);          // full set of 64 results
        add_reg (REG_IN_CHANNELS, 64);
        add_reg (REG_OUT_CHANNELS, 2);
        add_word(OP_PIXEL,  0, 62, 16'h7FFF, 0, 0);
        add_word(OP_PIXEL,  0, 63, 16'hC000, 0, 0);
        add_reg (REG_IN_CHANNELS, 3);
        add_word(OP_PIXEL,  0, 2, 16'h1000, 0, 0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the table; registers only change with the block idle.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                settle_idle();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_data);
            end else begin
                send_item(directed_rows[k].op, directed_rows[k].oi, directed_rows[k].ii,
                          directed_rows[k].val, directed_rows[k].typed, directed_rows[k].act);
            end
        end

        // Random phases: pick channel counts (mostly small, now and then the full table
        // on one side), then mostly complete pixels with random content, plus loads,
        // stray pixel words, unused opcodes and drain pauses.
        while (random_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0: begin
                    in_raw  = CNT_W'($urandom_range(64, 127));
                    out_raw = CNT_W'($urandom_range(0, 2));
                end
                1: begin
                    in_raw  = CNT_W'($urandom_range(0, 2));
                    out_raw = CNT_W'($urandom_range(64, 127));
                end
                default: begin
                    in_raw  = CNT_W'($urandom_range(0, 6));
                    out_raw = CNT_W'($urandom_range(0, 6));
                end
            endcase
            settle_idle();
            write_reg(REG_IN_CHANNELS, in_raw);
            write_reg(REG_OUT_CHANNELS, out_raw);
            n_in      = used_count(in_raw, MAX_IN);
            n_out     = used_count(out_raw, MAX_OUT);
            phase_end = random_words + $urandom_range(12, 24);

            while (random_words < phase_end) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // one pixel, channel by channel; sometimes only its tail
                        start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_in - 1) : 0;
                        for (int ic = start; ic < n_in; ic++) begin
                            send_item(OP_PIXEL, OUT_W'($urandom), IN_W'(ic), pick_value());
                            random_words++;
                        end
                        // hold off the sender once until the results have all drained
                        if (!paused_once) begin
                            drain_pause();
                            paused_once = 1'b1;
                        end
                    end
                    7, 8: begin
                        if ($urandom_range(0, 3) == 0) begin
                            oi = OUT_W'($urandom);
                            ii = IN_W'($urandom);
                        end else begin
                            oi = OUT_W'($urandom_range(0, n_out - 1));
                            ii = IN_W'($urandom_range(0, n_in - 1));
                        end
                        send_item(($urandom_range(0, 1) != 0) ? OP_WEIGHT : OP_BIAS,
                                  oi, ii, pick_value());
                        random_words++;
                    end
                    9: begin
                        drive_word(OP_UNUSED, OUT_W'($urandom), IN_W'($urandom),
                                   VAL_W'($urandom));
                    end
                    10: begin
                        // pixel word beyond the used channels: stored, never computed
                        if (n_in < MAX_IN) begin
                            send_item(OP_PIXEL, OUT_W'($urandom),
                                      IN_W'($urandom_range(n_in, MAX_IN - 1)), pick_value());
                            random_words++;
                        end
                    end
                    default: drain_pause();
                endcase
            end
        end

        settle_idle();
        repeat (40) @(negedge aclk);

        $display("Summary: %0d input words (%0d in random phases), %0d results checked,",
                 words_sent, random_words, results_checked);
        $display("Summary: %0d register writes, %0d mismatches", reg_writes, err_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
